// ----- design/gpn_pkg.sv -----
// shared types and constants of the gpio port change notifier
`timescale 1ns / 1ps
`default_nettype none

package gpn_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned SIG_W   = 8;
  localparam int unsigned TGT_W   = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PADDR_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_SAMPLE  = 3'd2,
    KIND_ADD_SIG = 3'd3,
    KIND_ADD_IRQ = 3'd4,
    KIND_RELEASE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_SIGNAL = 2'd1,
    STATUS_FULL       = 2'd2,
    STATUS_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_INVERT    = 3'd0,
    REG_INPUT_EN  = 3'd1,
    REG_OUTPUT_EN = 3'd2,
    REG_WATCH     = 3'd3,
    REG_SIG_LOW   = 3'd4,
    REG_SIG_HIGH  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FLUSH,
    ST_LOOK_RD,
    ST_LOOK_CHK,
    ST_STORE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] invert;
    logic [DATA_W-1:0] input_en;
    logic [DATA_W-1:0] output_en;
    logic [DATA_W-1:0] watch;
    logic [SIG_W-1:0]  sig_low;
    logic [SIG_W-1:0]  sig_high;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    status_t           status;
    logic              is_interrupt;
    logic [TGT_W-1:0]  notify_target;
    logic [SIG_W-1:0]  notify_signal;
    logic              is_notification;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ----- design/gpn_table.sv -----
// subscriber table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module gpn_table #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned DW    = 65
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/gpn_ctrl.sv -----
// item sequencer: port access, change scan, subscriber lookup, insert and removal
`timescale 1ns / 1ps
`default_nettype none

module gpn_ctrl #(
  parameter int unsigned PIN_WIDTH       = 32,
  parameter int unsigned MAX_SUBSCRIBERS = 8,
  parameter int unsigned AW              = 3,
  parameter int unsigned DW              = 65
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire gpn_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [gpn_pkg::KIND_W-1:0]  kind,
  input  wire logic [PIN_WIDTH-1:0]        pins,
  input  wire logic [PIN_WIDTH-1:0]        value,
  input  wire logic [PIN_WIDTH-1:0]        mask,
  input  wire logic [gpn_pkg::KEY_W-1:0]   owner_key,
  input  wire logic [gpn_pkg::SIG_W-1:0]   signal_number,
  input  wire logic [gpn_pkg::TGT_W-1:0]   target,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output gpn_pkg::result_t                 res,
  output logic                             mem_rd_en,
  output logic [AW-1:0]                    mem_rd_addr,
  input  wire logic [DW-1:0]               mem_rd_data,
  output logic                             mem_wr_en,
  output logic [AW-1:0]                    mem_wr_addr,
  output logic [DW-1:0]                    mem_wr_data
);

  localparam int unsigned MW = (PIN_WIDTH < 32) ? PIN_WIDTH : 32;
  localparam int unsigned CW = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int unsigned KW = gpn_pkg::KEY_W;
  localparam int unsigned SW = gpn_pkg::SIG_W;
  localparam int unsigned TW = gpn_pkg::TGT_W;

  gpn_pkg::state_t  state, state_next;
  gpn_pkg::kind_t   it_kind;
  logic [MW-1:0]    it_pins, it_value, it_mask;
  logic [KW-1:0]    it_key;
  logic [SW-1:0]    it_sig;
  logic [TW-1:0]    it_tgt;

  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    idx, idx_next;
  logic             found, found_next;
  logic [MW-1:0]    last_watched, last_watched_next;
  logic [MW-1:0]    changed, changed_next;
  logic             pend_valid, pend_valid_next;
  logic             pend_irq, pend_irq_next;
  logic [TW-1:0]    pend_tgt, pend_tgt_next;
  logic [SW-1:0]    pend_sig, pend_sig_next;
  gpn_pkg::status_t resp_status, resp_status_next;
  logic             out_load;
  gpn_pkg::result_t res_next;

  logic [MW-1:0]    inv, read_val, write_val, now_val;
  logic             sig_ok, out_free, full, more_p1, more_p2;
  logic [CW:0]      idx_p1, idx_p2;
  logic [MW-1:0]    rd_mask;
  logic             rd_irq;
  logic [TW-1:0]    rd_tgt;
  logic [SW-1:0]    rd_sig;
  logic [KW-1:0]    rd_key;
  logic             hit_key, hit_mask;
  logic [DW-1:0]    new_entry;

  assign inv       = cfg.invert[MW-1:0];
  assign read_val  = ((it_pins ^ inv) & it_mask) & cfg.input_en[MW-1:0];
  assign write_val = ((it_pins & ~it_mask) | ((it_value ^ inv) & it_mask))
                     & cfg.output_en[MW-1:0];
  assign now_val   = (it_pins ^ inv) & cfg.watch[MW-1:0];
  assign sig_ok    = (it_sig >= cfg.sig_low) && (it_sig <= cfg.sig_high);
  assign out_free  = !out_valid || out_ready;
  assign full      = (count == CW'(MAX_SUBSCRIBERS));
  assign idx_p1    = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2    = {1'b0, idx} + (CW+1)'(2);
  assign more_p1   = idx_p1 < {1'b0, count};
  assign more_p2   = idx_p2 < {1'b0, count};

  assign rd_mask   = mem_rd_data[MW-1:0];
  assign rd_irq    = mem_rd_data[MW];
  assign rd_tgt    = mem_rd_data[MW+1 +: TW];
  assign rd_sig    = mem_rd_data[MW+1+TW +: SW];
  assign rd_key    = mem_rd_data[MW+1+TW+SW +: KW];
  assign hit_key   = (rd_key == it_key);
  assign hit_mask  = |(changed & rd_mask);

  always_comb begin
    if (it_kind == gpn_pkg::KIND_ADD_IRQ) begin
      new_entry = {KW'(0), SW'(0), it_tgt, 1'b1, it_mask};
    end else begin
      new_entry = {it_key, it_sig, it_tgt, 1'b0, it_mask & cfg.watch[MW-1:0]};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gpn_pkg::ST_IDLE: begin
        if (in_valid) state_next = gpn_pkg::ST_EXEC;
      end
      gpn_pkg::ST_EXEC: begin
        unique case (it_kind)
          gpn_pkg::KIND_READ, gpn_pkg::KIND_WRITE: begin
            if (out_free) state_next = gpn_pkg::ST_IDLE;
          end
          gpn_pkg::KIND_SAMPLE: begin
            state_next = (count != '0) ? gpn_pkg::ST_SCAN_RD : gpn_pkg::ST_IDLE;
          end
          gpn_pkg::KIND_ADD_SIG: begin
            if (!sig_ok) state_next = gpn_pkg::ST_RESP;
            else if (count != '0) state_next = gpn_pkg::ST_LOOK_RD;
            else state_next = gpn_pkg::ST_STORE;
          end
          gpn_pkg::KIND_ADD_IRQ: state_next = gpn_pkg::ST_STORE;
          gpn_pkg::KIND_RELEASE: begin
            state_next = (count != '0) ? gpn_pkg::ST_LOOK_RD : gpn_pkg::ST_RESP;
          end
          default: state_next = gpn_pkg::ST_IDLE;
        endcase
      end
      gpn_pkg::ST_SCAN_RD: state_next = gpn_pkg::ST_SCAN_CHK;
      gpn_pkg::ST_SCAN_CHK: begin
        if (!(hit_mask && pend_valid && !out_free)) begin
          state_next = more_p1 ? gpn_pkg::ST_SCAN_RD : gpn_pkg::ST_FLUSH;
        end
      end
      gpn_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = gpn_pkg::ST_IDLE;
      end
      gpn_pkg::ST_LOOK_RD: state_next = gpn_pkg::ST_LOOK_CHK;
      gpn_pkg::ST_LOOK_CHK: begin
        if (hit_key) begin
          if (it_kind == gpn_pkg::KIND_ADD_SIG) state_next = gpn_pkg::ST_STORE;
          else state_next = more_p1 ? gpn_pkg::ST_SHIFT_RD : gpn_pkg::ST_RESP;
        end else if (more_p1) begin
          state_next = gpn_pkg::ST_LOOK_RD;
        end else begin
          state_next = (it_kind == gpn_pkg::KIND_ADD_SIG) ? gpn_pkg::ST_STORE
                                                           : gpn_pkg::ST_RESP;
        end
      end
      gpn_pkg::ST_STORE: state_next = gpn_pkg::ST_RESP;
      gpn_pkg::ST_SHIFT_RD: state_next = gpn_pkg::ST_SHIFT_WR;
      gpn_pkg::ST_SHIFT_WR: begin
        state_next = more_p2 ? gpn_pkg::ST_SHIFT_RD : gpn_pkg::ST_RESP;
      end
      gpn_pkg::ST_RESP: begin
        if (out_free) state_next = gpn_pkg::ST_IDLE;
      end
      default: state_next = gpn_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready          = (state == gpn_pkg::ST_IDLE);
    mem_rd_en         = 1'b0;
    mem_rd_addr       = idx[AW-1:0];
    mem_wr_en         = 1'b0;
    mem_wr_addr       = idx[AW-1:0];
    mem_wr_data       = new_entry;
    out_load          = 1'b0;
    res_next          = '0;
    count_next        = count;
    idx_next          = idx;
    found_next        = found;
    last_watched_next = last_watched;
    changed_next      = changed;
    pend_valid_next   = pend_valid;
    pend_irq_next     = pend_irq;
    pend_tgt_next     = pend_tgt;
    pend_sig_next     = pend_sig;
    resp_status_next  = resp_status;
    unique case (state)
      gpn_pkg::ST_IDLE: begin
      end
      gpn_pkg::ST_EXEC: begin
        idx_next        = '0;
        found_next      = 1'b0;
        pend_valid_next = 1'b0;
        unique case (it_kind)
          gpn_pkg::KIND_READ: begin
            out_load          = out_free;
            res_next.data_out = gpn_pkg::DATA_W'(read_val);
            res_next.last     = 1'b1;
          end
          gpn_pkg::KIND_WRITE: begin
            out_load          = out_free;
            res_next.data_out = gpn_pkg::DATA_W'(write_val);
            res_next.last     = 1'b1;
          end
          gpn_pkg::KIND_SAMPLE: begin
            last_watched_next = now_val;
            changed_next      = now_val ^ last_watched;
          end
          gpn_pkg::KIND_ADD_SIG: begin
            if (!sig_ok) resp_status_next = gpn_pkg::STATUS_BAD_SIGNAL;
          end
          gpn_pkg::KIND_RELEASE: begin
            if (count == '0) resp_status_next = gpn_pkg::STATUS_NOT_FOUND;
          end
          default: begin
          end
        endcase
      end
      gpn_pkg::ST_SCAN_RD, gpn_pkg::ST_LOOK_RD: begin
        mem_rd_en = 1'b1;
      end
      gpn_pkg::ST_SCAN_CHK: begin
        if (!(hit_mask && pend_valid && !out_free)) begin
          if (hit_mask) begin
            if (pend_valid) begin
              out_load                 = 1'b1;
              res_next.is_interrupt    = pend_irq;
              res_next.notify_target   = pend_tgt;
              res_next.notify_signal   = pend_sig;
              res_next.is_notification = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_irq_next   = rd_irq;
            pend_tgt_next   = rd_tgt;
            pend_sig_next   = rd_irq ? SW'(0) : rd_sig;
          end
          idx_next = idx_p1[CW-1:0];
        end
      end
      gpn_pkg::ST_FLUSH: begin
        out_load                 = pend_valid && out_free;
        res_next.is_interrupt    = pend_irq;
        res_next.notify_target   = pend_tgt;
        res_next.notify_signal   = pend_sig;
        res_next.is_notification = 1'b1;
        res_next.last            = 1'b1;
      end
      gpn_pkg::ST_LOOK_CHK: begin
        if (hit_key) begin
          found_next = 1'b1;
          if (it_kind != gpn_pkg::KIND_ADD_SIG && !more_p1) begin
            count_next       = count - CW'(1);
            resp_status_next = gpn_pkg::STATUS_OK;
          end
        end else begin
          idx_next = idx_p1[CW-1:0];
          if (!more_p1 && it_kind != gpn_pkg::KIND_ADD_SIG) begin
            resp_status_next = gpn_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      gpn_pkg::ST_STORE: begin
        if (found) begin
          mem_wr_en        = 1'b1;
          resp_status_next = gpn_pkg::STATUS_OK;
        end else if (full) begin
          resp_status_next = gpn_pkg::STATUS_FULL;
        end else begin
          mem_wr_en        = 1'b1;
          mem_wr_addr      = count[AW-1:0];
          count_next       = count + CW'(1);
          resp_status_next = gpn_pkg::STATUS_OK;
        end
      end
      gpn_pkg::ST_SHIFT_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = idx_p1[AW-1:0];
      end
      gpn_pkg::ST_SHIFT_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
        idx_next    = idx_p1[CW-1:0];
        if (!more_p2) begin
          count_next       = count - CW'(1);
          resp_status_next = gpn_pkg::STATUS_OK;
        end
      end
      gpn_pkg::ST_RESP: begin
        out_load        = out_free;
        res_next.status = resp_status;
        res_next.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gpn_pkg::ST_IDLE;
      out_valid    <= 1'b0;
      count        <= '0;
      last_watched <= '0;
      pend_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      last_watched <= last_watched_next;
      pend_valid   <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_kind  <= gpn_pkg::kind_t'(kind);
      it_pins  <= pins[MW-1:0];
      it_value <= value[MW-1:0];
      it_mask  <= mask[MW-1:0];
      it_key   <= owner_key;
      it_sig   <= signal_number;
      it_tgt   <= target;
    end
    idx         <= idx_next;
    found       <= found_next;
    changed     <= changed_next;
    pend_irq    <= pend_irq_next;
    pend_tgt    <= pend_tgt_next;
    pend_sig    <= pend_sig_next;
    resp_status <= resp_status_next;
    if (out_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/gpio_port_change_notifier_top.sv -----
// top level of the gpio port change notifier with its register file
//
// Items enter on in_valid/in_ready with kind, pins, value, mask, owner_key,
// signal_number and target; results leave on out_valid/out_ready, one per
// port access or table command and one per matching subscriber on a pin
// sample, the final result of an item marked by last. A pin sample with no
// matching subscriber and an unused kind give no result.
// One item is worked at a time. A read or write result is registered from the
// execute state, once the output register is free; a table command or pin sample
// walks the subscriber memory entry by entry (one read, then one check or move
// per entry), set by the single read port of the table.
// The output register holds a result while the receiver stalls; the sequencer
// waits only when it has a further result to hand over. in_ready is high
// whenever no item is in work.
// Reset clears the registers to their defaults, the stored pin state and the
// subscriber count; the table memory needs no clearing pass.
// Registers are written through the APB port at byte address 4 * index.
`timescale 1ns / 1ps
`default_nettype none

module gpio_port_change_notifier_top #(
  parameter int unsigned PIN_WIDTH       = 32,
  parameter int unsigned MAX_SUBSCRIBERS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [gpn_pkg::KIND_W-1:0]   kind,
  input  wire logic [PIN_WIDTH-1:0]         pins,
  input  wire logic [PIN_WIDTH-1:0]         value,
  input  wire logic [PIN_WIDTH-1:0]         mask,
  input  wire logic [gpn_pkg::KEY_W-1:0]    owner_key,
  input  wire logic [gpn_pkg::SIG_W-1:0]    signal_number,
  input  wire logic [gpn_pkg::TGT_W-1:0]    target,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [gpn_pkg::DATA_W-1:0]        data_out,
  output logic [1:0]                        status,
  output logic                              is_interrupt,
  output logic [gpn_pkg::TGT_W-1:0]         notify_target,
  output logic [gpn_pkg::SIG_W-1:0]         notify_signal,
  output logic                              is_notification,
  output logic                              last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gpn_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [gpn_pkg::DATA_W-1:0]   pwdata,
  output logic [gpn_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int unsigned MW = (PIN_WIDTH < 32) ? PIN_WIDTH : 32;
  localparam int unsigned AW = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam int unsigned DW = MW + 1 + gpn_pkg::TGT_W + gpn_pkg::SIG_W + gpn_pkg::KEY_W;

  gpn_pkg::cfg_t     cfg;
  gpn_pkg::reg_idx_t reg_idx;
  gpn_pkg::result_t  res;
  logic              cfg_we;
  logic              mem_rd_en, mem_wr_en;
  logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
  logic [DW-1:0]     mem_rd_data, mem_wr_data;

  assign pready  = 1'b1;
  assign reg_idx = gpn_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert    <= '0;
      cfg.input_en  <= '0;
      cfg.output_en <= '0;
      cfg.watch     <= '0;
      cfg.sig_low   <= '0;
      cfg.sig_high  <= gpn_pkg::SIG_W'(3);
    end else if (cfg_we) begin
      unique case (reg_idx)
        gpn_pkg::REG_INVERT:    cfg.invert    <= pwdata;
        gpn_pkg::REG_INPUT_EN:  cfg.input_en  <= pwdata;
        gpn_pkg::REG_OUTPUT_EN: cfg.output_en <= pwdata;
        gpn_pkg::REG_WATCH:     cfg.watch     <= pwdata;
        gpn_pkg::REG_SIG_LOW:   cfg.sig_low   <= pwdata[gpn_pkg::SIG_W-1:0];
        gpn_pkg::REG_SIG_HIGH:  cfg.sig_high  <= pwdata[gpn_pkg::SIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gpn_pkg::REG_INVERT:    prdata = cfg.invert;
      gpn_pkg::REG_INPUT_EN:  prdata = cfg.input_en;
      gpn_pkg::REG_OUTPUT_EN: prdata = cfg.output_en;
      gpn_pkg::REG_WATCH:     prdata = cfg.watch;
      gpn_pkg::REG_SIG_LOW:   prdata = gpn_pkg::DATA_W'(cfg.sig_low);
      gpn_pkg::REG_SIG_HIGH:  prdata = gpn_pkg::DATA_W'(cfg.sig_high);
      default:                prdata = '0;
    endcase
  end

  gpn_ctrl #(
    .PIN_WIDTH       (PIN_WIDTH),
    .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS),
    .AW              (AW),
    .DW              (DW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .pins          (pins),
    .value         (value),
    .mask          (mask),
    .owner_key     (owner_key),
    .signal_number (signal_number),
    .target        (target),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .res           (res),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data)
  );

  gpn_table #(
    .DEPTH (MAX_SUBSCRIBERS),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign data_out        = res.data_out;
  assign status          = res.status;
  assign is_interrupt    = res.is_interrupt;
  assign notify_target   = res.notify_target;
  assign notify_signal   = res.notify_signal;
  assign is_notification = res.is_notification;
  assign last            = res.last;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  a_note_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_notification |-> status == gpn_pkg::STATUS_OK && data_out == '0)
    else $error("notification carries status or data");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_notification |-> last && !is_interrupt)
    else $error("single result not marked last");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");
`endif

endmodule

`default_nettype wire
